/* design/ptst_pkg.sv */
// Package for the periodic timer slot table: field widths, operation and
// result codes, sequencer states and the result type of the shared unit.
// No dependencies.
package ptst_pkg;

	localparam int OP_W       = 2;
	localparam int INTERVAL_W = 16;
	localparam int SLOT_W     = 4;
	localparam int KIND_W     = 2;
	localparam int CNT_W      = 4;
	localparam int TICK_W     = 8;
	localparam int ELAPSED_W  = 17;

	localparam logic [TICK_W-1:0] TICK_MS_RESET = TICK_W'(25);

	localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_EXPIRY = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_ADD    = 4'b0010,
		S_REMOVE = 4'b0100,
		S_TICK   = 4'b1000
	} state_t;

	typedef struct packed {
		logic [ELAPSED_W-1:0] sum;
		logic                 expire;
	} alu_res_t;

endpackage

/* design/ptst_cmd_if.sv */
// Command channel of the periodic timer slot table: valid/ready handshake
// carrying operation, interval and slot. Depends on ptst_pkg.
interface ptst_cmd_if import ptst_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [OP_W-1:0]       operation;
	logic [INTERVAL_W-1:0] interval_ms;
	logic [SLOT_W-1:0]     slot;

	modport source (output valid, output operation, output interval_ms, output slot,
		input ready);
	modport sink (input valid, input operation, input interval_ms, input slot,
		output ready);
endinterface

/* design/ptst_rsp_if.sv */
// Result channel of the periodic timer slot table: valid/ready handshake
// carrying one result item. Depends on ptst_pkg.
interface ptst_rsp_if import ptst_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic              ok;
	logic [SLOT_W-1:0] slot_id;
	logic [CNT_W-1:0]  active_count;
	logic              last;

	modport source (output valid, output kind, output ok, output slot_id,
		output active_count, output last, input ready);
	modport sink (input valid, input kind, input ok, input slot_id,
		input active_count, input last, output ready);
endinterface

/* design/ptst_alu.sv */
// Shared add and compare unit: advances one elapsed count by the tick step
// and checks it against the period. Depends on ptst_pkg.
module ptst_alu import ptst_pkg::*; (
	input  logic [ELAPSED_W-1:0]  elapsed,
	input  logic [TICK_W-1:0]     tick_ms,
	input  logic [INTERVAL_W-1:0] period,
	output alu_res_t              res
);

	logic [ELAPSED_W-1:0] sum;

	assign sum        = elapsed + ELAPSED_W'(tick_ms);
	assign res.sum    = sum;
	assign res.expire = (sum >= ELAPSED_W'(period));

endmodule

/* design/ptst_ctrl.sv */
// Sequencer and slot registers of the periodic timer slot table. Walks the slots
// one per cycle through the shared unit, pausing while a result waits, and owns
// the result register. Depends on ptst_pkg, ptst_cmd_if, ptst_rsp_if, ptst_alu.
module ptst_ctrl import ptst_pkg::*; #(
	parameter int NUM_SLOTS = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [TICK_W-1:0] tick_ms,
	ptst_cmd_if.sink          cmd,
	ptst_rsp_if.source        rsp
);

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [SLOT_W-1:0] END_IDX = SLOT_W'(NUM_SLOTS);

	state_t                state_q, state_d;
	logic [SLOT_W-1:0]     idx_q, idx_d;
	logic                  pend_q, pend_d;
	logic [SLOT_W-1:0]     pend_slot_q, pend_slot_d;
	logic [INTERVAL_W-1:0] interval_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [NUM_SLOTS-1:0]  active_q;
	logic [CNT_W-1:0]      count_q, count_d;
	logic [INTERVAL_W-1:0] period_q  [NUM_SLOTS];
	logic [ELAPSED_W-1:0]  elapsed_q [NUM_SLOTS];

	logic                  rsp_valid_q;
	logic [KIND_W-1:0]     rsp_kind_q;
	logic                  rsp_ok_q;
	logic [SLOT_W-1:0]     rsp_slot_q;
	logic [CNT_W-1:0]      rsp_count_q;
	logic                  rsp_last_q;

	logic [IDX_W-1:0]      cur;
	logic [IDX_W-1:0]      rem_idx;
	logic                  rem_ok;
	logic                  at_end;
	logic                  out_free;
	logic                  accept;
	alu_res_t              alu;

	logic                  emit;
	logic [KIND_W-1:0]     e_kind;
	logic                  e_ok;
	logic [SLOT_W-1:0]     e_slot;
	logic [CNT_W-1:0]      e_count;
	logic                  e_last;
	logic                  set_act;
	logic                  clr_act;
	logic                  wr_el;
	logic [IDX_W-1:0]      wr_idx;
	logic [ELAPSED_W-1:0]  el_val;
	logic                  wr_per;

	assign cur      = idx_q[IDX_W-1:0];
	assign rem_idx  = slot_q[IDX_W-1:0];
	assign rem_ok   = (slot_q < END_IDX);
	assign at_end   = (idx_q == END_IDX);
	assign out_free = !rsp_valid_q || rsp.ready;
	assign cmd.ready = (state_q == S_IDLE);
	assign accept   = cmd.valid && cmd.ready;

	ptst_alu u_alu (
		.elapsed (elapsed_q[cur]),
		.tick_ms (tick_ms),
		.period  (period_q[cur]),
		.res     (alu)
	);

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		pend_d      = pend_q;
		pend_slot_d = pend_slot_q;
		count_d     = count_q;
		emit        = 1'b0;
		e_kind      = KIND_ADD;
		e_ok        = 1'b0;
		e_slot      = '0;
		e_count     = count_q;
		e_last      = 1'b1;
		set_act     = 1'b0;
		clr_act     = 1'b0;
		wr_el       = 1'b0;
		wr_idx      = cur;
		el_val      = alu.sum;
		wr_per      = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					case (cmd.operation)
						OP_TICK: begin
							state_d = S_TICK;
							idx_d   = '0;
							pend_d  = 1'b0;
						end
						OP_ADD: begin
							state_d = S_ADD;
							idx_d   = '0;
						end
						OP_REMOVE: state_d = S_REMOVE;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_ADD: begin
				if (at_end) begin
					if (out_free) begin
						emit    = 1'b1;
						state_d = S_IDLE;
					end
				end else if (!active_q[cur]) begin
					if (out_free) begin
						set_act = 1'b1;
						wr_per  = 1'b1;
						wr_el   = 1'b1;
						el_val  = '0;
						count_d = count_q + CNT_W'(1);
						emit    = 1'b1;
						e_ok    = 1'b1;
						e_slot  = idx_q;
						e_count = count_d;
						state_d = S_IDLE;
					end
				end else begin
					idx_d = idx_q + SLOT_W'(1);
				end
			end
			S_REMOVE: begin
				if (out_free) begin
					emit    = 1'b1;
					e_kind  = KIND_REMOVE;
					state_d = S_IDLE;
					if (rem_ok) begin
						clr_act = 1'b1;
						wr_el   = 1'b1;
						wr_idx  = rem_idx;
						el_val  = '0;
						if (active_q[rem_idx]) begin
							count_d = count_q - CNT_W'(1);
						end
						e_ok    = 1'b1;
						e_slot  = slot_q;
						e_count = count_d;
					end
				end
			end
			S_TICK: begin
				// An expiry is held back until the next one is found or the walk
				// ends, so that the final item of the tick can carry last.
				if (at_end) begin
					if (!pend_q) begin
						state_d = S_IDLE;
					end else if (out_free) begin
						emit    = 1'b1;
						e_kind  = KIND_EXPIRY;
						e_ok    = 1'b1;
						e_slot  = pend_slot_q;
						pend_d  = 1'b0;
						state_d = S_IDLE;
					end
				end else if (!active_q[cur]) begin
					idx_d = idx_q + SLOT_W'(1);
				end else if (!alu.expire) begin
					wr_el = 1'b1;
					idx_d = idx_q + SLOT_W'(1);
				end else if (!pend_q || out_free) begin
					wr_el  = 1'b1;
					el_val = '0;
					if (pend_q) begin
						emit   = 1'b1;
						e_kind = KIND_EXPIRY;
						e_ok   = 1'b1;
						e_slot = pend_slot_q;
						e_last = 1'b0;
					end
					pend_d      = 1'b1;
					pend_slot_d = idx_q;
					idx_d       = idx_q + SLOT_W'(1);
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			pend_slot_q <= '0;
			active_q    <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			idx_q       <= idx_d;
			pend_q      <= pend_d;
			pend_slot_q <= pend_slot_d;
			count_q     <= count_d;
			if (set_act) begin
				active_q[cur] <= 1'b1;
			end
			if (clr_act) begin
				active_q[rem_idx] <= 1'b0;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			interval_q <= cmd.interval_ms;
			slot_q     <= cmd.slot;
		end
		if (wr_per) begin
			period_q[cur] <= interval_q;
		end
		if (wr_el) begin
			elapsed_q[wr_idx] <= el_val;
		end
		if (emit) begin
			rsp_kind_q  <= e_kind;
			rsp_ok_q    <= e_ok;
			rsp_slot_q  <= e_slot;
			rsp_count_q <= e_count;
			rsp_last_q  <= e_last;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.kind         = rsp_kind_q;
	assign rsp.ok           = rsp_ok_q;
	assign rsp.slot_id      = rsp_slot_q;
	assign rsp.active_count = rsp_count_q;
	assign rsp.last         = rsp_last_q;

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'($countones(active_q)))
		else $error("active count register disagrees with the active flags");

	a_pend_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> state_q == S_TICK)
		else $error("held expiry outlived its tick walk");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= END_IDX)
		else $error("slot walk ran beyond the table");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_kind_q != KIND_EXPIRY) |-> rsp_last_q)
		else $error("add or remove answer without last");

endmodule

/* design/periodic_timer_slot_table_core.sv */
// Top level of the periodic timer slot table: tick step register and the
// slot sequencer. Depends on ptst_pkg, ptst_cmd_if, ptst_rsp_if, ptst_ctrl.
// Operations: a remove answers from its own state; an add walks to the lowest
// free slot, or past the last one when the table is full; a tick walks every
// slot, one slot per cycle through the shared adder and comparator, pausing
// while the result register is not taken.
// The command side is ready only idle, so each command is through before the next is taken.
// Reset: tick_ms returns to 25 and every slot is inactive; periods and elapsed counts
// are not cleared, as an add writes both before they are read.
module periodic_timer_slot_table_core import ptst_pkg::*; #(
	parameter int NUM_SLOTS = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick_ms_we,
	input  logic [TICK_W-1:0] tick_ms_wdata,
	ptst_cmd_if.sink          cmd,
	ptst_rsp_if.source        rsp
);

	logic [TICK_W-1:0] tick_ms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_ms_q <= TICK_MS_RESET;
		end else if (tick_ms_we) begin
			tick_ms_q <= tick_ms_wdata;
		end
	end

	ptst_ctrl #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick_ms (tick_ms_q),
		.cmd     (cmd),
		.rsp     (rsp)
	);

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for periodic_timer_slot_table_core. A mirror of the slot table
// predicts every result item, while random gaps and stalls on both channels load the handshakes.
// Depends on ptst_pkg, ptst_cmd_if, ptst_rsp_if and the core itself.
module tb_top;
	import ptst_pkg::*;

	localparam int SLOTS         = 15;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 2 * SLOTS + 8;
	localparam int PHASE_ITEMS   = 45;

	// The operation code that the block must ignore.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              ok;
		logic [SLOT_W-1:0] slot_id;
		logic [CNT_W-1:0]  active_count;
		logic              last;
	} timer_result_t;

	class timer_slot_mirror;
		bit                    active [SLOTS];
		logic [INTERVAL_W-1:0] period [SLOTS];
		logic [ELAPSED_W-1:0]  elapsed [SLOTS];
		logic [TICK_W-1:0]     tick_step;
		timer_result_t         due_results [$];
		int                    errors;

		function new();
			tick_step = TICK_MS_RESET;
			errors = 0;
			foreach (active[i]) active[i] = 1'b0;
		endfunction

		function logic [CNT_W-1:0] active_slots();
			int n;
			n = 0;
			foreach (active[i]) if (active[i]) n++;
			return CNT_W'(n);
		endfunction

		function void note_command(logic [OP_W-1:0] op, logic [INTERVAL_W-1:0] iv,
				logic [SLOT_W-1:0] sl);
			timer_result_t    r;
			timer_result_t    batch [$];
			logic [CNT_W-1:0] n_act;
			int               free_slot;
			case (op)
				OP_ADD: begin
					free_slot = -1;
					for (int i = 0; i < SLOTS; i++)
						if (!active[i] && free_slot < 0) free_slot = i;
					if (free_slot >= 0) begin
						active[free_slot] = 1'b1;
						period[free_slot] = iv;
						elapsed[free_slot] = '0;
					end
					r.kind = KIND_ADD;
					r.ok = (free_slot >= 0);
					r.slot_id = (free_slot >= 0) ? SLOT_W'(free_slot) : '0;
					r.active_count = active_slots();
					r.last = 1'b1;
					due_results.push_back(r);
				end
				OP_REMOVE: begin
					if (sl < SLOTS) begin
						active[sl] = 1'b0;
						elapsed[sl] = '0;
						r.ok = 1'b1;
						r.slot_id = sl;
					end else begin
						r.ok = 1'b0;
						r.slot_id = '0;
					end
					r.kind = KIND_REMOVE;
					r.active_count = active_slots();
					r.last = 1'b1;
					due_results.push_back(r);
				end
				OP_TICK: begin
					n_act = active_slots();
					for (int i = 0; i < SLOTS; i++) begin
						if (active[i]) begin
							elapsed[i] = elapsed[i] + ELAPSED_W'(tick_step);
							if (elapsed[i] >= ELAPSED_W'(period[i])) begin
								elapsed[i] = '0;
								r.kind = KIND_EXPIRY;
								r.ok = 1'b1;
								r.slot_id = SLOT_W'(i);
								r.active_count = n_act;
								r.last = 1'b0;
								batch.push_back(r);
							end
						end
					end
					// A tick with no expiry yields nothing at all.
					if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
					foreach (batch[k]) due_results.push_back(batch[k]);
				end
				default: ;
			endcase
		endfunction

		task report_mismatch(string what);
			errors++;
			if (errors <= 100) $display("[%0t] mismatch: %s", $time, what);
		endtask

		task compare_field(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
		endtask

		task check_result(timer_result_t got);
			timer_result_t want;
			if (due_results.size() == 0) begin
				report_mismatch($sformatf("result kind %0d slot %0d with none outstanding",
					got.kind, got.slot_id));
				return;
			end
			want = due_results.pop_front();
			compare_field("kind", 8'(got.kind), 8'(want.kind));
			compare_field("ok", 8'(got.ok), 8'(want.ok));
			compare_field("slot_id", 8'(got.slot_id), 8'(want.slot_id));
			compare_field("active_count", 8'(got.active_count), 8'(want.active_count));
			compare_field("last", 8'(got.last), 8'(want.last));
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              tick_ms_we;
	logic [TICK_W-1:0] tick_ms_wdata;
	bit                steady = 1'b0;
	bit                hold_off_req = 1'b0;
	timer_slot_mirror  table_mirror;

	always #6 clk = ~clk;

	ptst_cmd_if cmd_ch ();
	ptst_rsp_if rsp_ch ();

	periodic_timer_slot_table_core #(.NUM_SLOTS(SLOTS)) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.tick_ms_we    (tick_ms_we),
		.tick_ms_wdata (tick_ms_wdata),
		.cmd           (cmd_ch),
		.rsp           (rsp_ch)
	);

	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int stall_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return 1;
		if (r < 90) return $urandom_range(2, 4);
		return $urandom_range(10, 30);
	endfunction

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			table_mirror.check_result(timer_result_t'({rsp_ch.kind, rsp_ch.ok, rsp_ch.slot_id,
				rsp_ch.active_count, rsp_ch.last}));
	end

	// Result side: random stalls, steady stretches, and on request one long hold-off
	// so that the block backs up and stops taking commands.
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (steady) begin
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 3) != 0);
				repeat (stall_cycles()) @(posedge clk);
			end
		end
	end

	initial begin
		#10ms;
		$display("periodic_timer_slot_table_core verification failed");
		$finish;
	end

	task automatic send_command(logic [OP_W-1:0] op, logic [INTERVAL_W-1:0] iv,
			logic [SLOT_W-1:0] sl);
		int gap;
		gap = gap_cycles();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.operation <= op;
		cmd_ch.interval_ms <= iv;
		cmd_ch.slot <= sl;
		do @(posedge clk); while (!cmd_ch.ready);
		table_mirror.note_command(op, iv, sl);
	endtask

	// A tick that expires nothing leaves no trace, so the sequencer gets a full walk's
	// worth of cycles beyond the last result before anything else is touched.
	task automatic settle_table();
		cmd_ch.valid <= 1'b0;
		while (table_mirror.due_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_tick_step(logic [TICK_W-1:0] value);
		tick_ms_we <= 1'b1;
		tick_ms_wdata <= value;
		@(posedge clk);
		table_mirror.tick_step = value;
		tick_ms_we <= 1'b0;
	endtask

	task automatic directed_items();
		send_command(OP_UNUSED, 16'hFFFF, 4'hF);
		send_command(OP_TICK, 16'h0000, 4'h0);
		send_command(OP_REMOVE, 16'h0000, SLOT_W'(SLOTS));
		send_command(OP_REMOVE, 16'h0000, 4'd3);
		send_command(OP_ADD, 16'd0, 4'h0);
		send_command(OP_ADD, 16'hFFFF, 4'h0);
		send_command(OP_ADD, 16'd25, 4'h0);
		send_command(OP_ADD, 16'd50, 4'h0);
		repeat (2) send_command(OP_TICK, 16'h0000, 4'h0);
		for (int i = 0; i < SLOTS - 4; i++) send_command(OP_ADD, INTERVAL_W'(i + 1), 4'h0);
		// The table is full now, so this add must fail.
		send_command(OP_ADD, 16'd7, 4'h0);
		send_command(OP_TICK, 16'h0000, 4'h0);
		send_command(OP_REMOVE, 16'h0000, SLOT_W'(SLOTS - 1));
		send_command(OP_REMOVE, 16'h0000, 4'h0);
	endtask

	task automatic run_random(int count, bit squeeze);
		int                    issued;
		int                    r;
		int                    pick;
		int                    span;
		logic [OP_W-1:0]       op;
		logic [INTERVAL_W-1:0] iv;
		logic [SLOT_W-1:0]     sl;
		logic [SLOT_W-1:0]     live [$];
		issued = 0;
		if (squeeze) hold_off_req = 1'b1;
		while (issued < count) begin
			steady = (issued >= count / 3) && (issued < count / 2);
			r = $urandom_range(0, 99);
			iv = $urandom_range(0, 65535);
			sl = $urandom_range(0, 15);
			if (r < 5) begin
				op = OP_UNUSED;
			end else if (r < 37) begin
				op = OP_ADD;
				// Intervals of a few ticks keep expiries coming; full-range ones are rarer.
				span = int'(table_mirror.tick_step) * 6 + 8;
				pick = $urandom_range(0, 99);
				if (pick >= 25) iv = $urandom_range(0, span);
				else if (pick >= 15) iv = '0;
			end else if (r < 60) begin
				op = OP_REMOVE;
				live.delete();
				foreach (table_mirror.active[i])
					if (table_mirror.active[i]) live.push_back(SLOT_W'(i));
				if (live.size() > 0 && $urandom_range(0, 99) < 70)
					sl = live[$urandom_range(0, live.size() - 1)];
			end else begin
				op = OP_TICK;
			end
			send_command(op, iv, sl);
			if (op != OP_UNUSED) issued++;
		end
		steady = 1'b0;
	endtask

	initial begin
		logic [TICK_W-1:0] tick_plan [5];
		table_mirror = new();
		arst_n <= 1'b0;
		tick_ms_we <= 1'b0;
		tick_ms_wdata <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.operation <= OP_TICK;
		cmd_ch.interval_ms <= '0;
		cmd_ch.slot <= '0;
		tick_plan = '{8'd255, 8'd1, 8'd0, 8'd0, TICK_MS_RESET};
		tick_plan[3] = $urandom_range(2, 254);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		directed_items();
		settle_table();
		foreach (tick_plan[p]) begin
			write_tick_step(tick_plan[p]);
			run_random(PHASE_ITEMS, (p == 0) || (p == 3));
			settle_table();
		end
		if (table_mirror.errors == 0)
			$display("periodic_timer_slot_table_core verification clean");
		else
			$display("periodic_timer_slot_table_core verification failed");
		$finish;
	end

endmodule
